// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the RTL of the reverb suppressor.
// Depends on a clock named i_clk and an active-low reset named i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== hw/rtl/srs_pkg.sv =====
// Shared types and constants of the spectral reverb suppressor.
// No dependencies; every RTL file of the block imports it.
package srs_pkg;

    localparam int FFT_SIZE_DEF = 512;
    localparam logic [14:0] DECAY_RST = 15'd31457;
    localparam logic [16:0] SUPP_RST  = 17'd58982;
    localparam logic [16:0] UNITY_Q16 = 17'd65536;
    localparam logic [15:0] ONE_Q15   = 16'd32768;
    localparam logic [15:0] HALF_Q15  = 16'd16384;

    // Configuration register indexes.
    typedef enum logic {
        CFG_DECAY = 1'b0,
        CFG_SUPP  = 1'b1
    } t_cfg_reg;

    // Input item as it travels down the pipeline.
    typedef struct packed {
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic [8:0]         idx;
        logic               first;
        logic               inrng;
    } t_item;

endpackage

// ===== hw/rtl/spectral_reverb_suppressor_core.sv =====
// Top level of the spectral reverb suppressor: ports, configuration, scaling, output.
// Depends on srs_pkg, srs_mag, srs_est, srs_mask and assert_macros.svh.
//
// Takes one complex bin per cycle. It presents the bin, scaled by a dereverberation
// mask, from its output register, with one result per item. The
// pipeline is 42 register stages long: the input register, squares and sum (2),
// a 16-stage square root, the estimate update (2), the product and saturation
// stages (2), a 16-stage restoring division, the mask, the scaling product and the
// output register. The per-bin estimate lives in a 257-entry memory
// (FFT_SIZE/2+1) whose update loop closes in one stage, so the same bin may
// arrive on consecutive cycles. Every stage holds while a result waits at the
// output; entries of the estimate memory are meaningful only after a first-frame
// item for that bin.
`include "assert_macros.svh"
module spectral_reverb_suppressor_core import srs_pkg::*; #(
    parameter int FFT_SIZE = FFT_SIZE_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration write port.
    input  logic         i_cfg_we,
    input  logic         i_cfg_idx,
    input  logic [16:0]  i_cfg_wdata,
    // Input items.
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [47:0]  i_s_axis_tdata,  // bin_real[15:0], bin_imag[31:16], bin_index[40:32]
    input  logic [0:0]   i_s_axis_tuser,  // first_frame[0]
    // Result items.
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [63:0]  o_m_axis_tdata   // out_real[15:0], out_imag[31:16],
                                          // out_bin[40:32], gain_mask[57:41]
);

    localparam int NumBins = FFT_SIZE / 2 + 1;

    logic [14:0] r_decay;
    logic [16:0] r_supp;

    logic        en;
    t_item       in_item;

    logic        r_in_v;
    t_item       r_in_item;

    logic        mag_v;
    t_item       mag_item;
    logic [15:0] mag;
    logic        est_v;
    t_item       est_item;
    logic [15:0] est_mag;
    logic [16:0] est;
    logic        msk_v;
    t_item       msk_item;
    logic [16:0] msk;

    logic [15:0] abs_re;
    logic [15:0] abs_im;

    logic        r_p_v;
    t_item       r_p_item;
    logic [16:0] r_p_mask;
    logic [33:0] r_p_re;
    logic [33:0] r_p_im;

    logic        r_out_v;
    logic [15:0] r_out_re;
    logic [15:0] r_out_im;
    logic [8:0]  r_out_bin;
    logic [16:0] r_out_mask;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay <= DECAY_RST;
            r_supp  <= SUPP_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_idx))
                CFG_DECAY: r_decay <= i_cfg_wdata[14:0];
                CFG_SUPP:  r_supp  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // The whole pipeline moves while the output register is free or being taken.
    assign en              = !r_out_v || i_m_axis_tready;
    assign o_s_axis_tready = en;

    assign in_item.re    = i_s_axis_tdata[15:0];
    assign in_item.im    = i_s_axis_tdata[31:16];
    assign in_item.idx   = i_s_axis_tdata[40:32];
    assign in_item.first = i_s_axis_tuser[0];
    assign in_item.inrng = (32'(i_s_axis_tdata[40:32]) < 32'(NumBins));

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v <= 1'b0;
        end else if (en) begin
            r_in_v <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_item <= in_item;
        end
    end

    srs_mag u_mag (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r_in_v),
        .i_item  (r_in_item),
        .o_valid (mag_v),
        .o_item  (mag_item),
        .o_mag   (mag)
    );

    srs_est #(.FFT_SIZE(FFT_SIZE)) u_est (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_decay (r_decay),
        .i_valid (mag_v),
        .i_item  (mag_item),
        .i_mag   (mag),
        .o_valid (est_v),
        .o_item  (est_item),
        .o_mag   (est_mag),
        .o_est   (est)
    );

    srs_mask u_mask (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_supp  (r_supp),
        .i_valid (est_v),
        .i_item  (est_item),
        .i_mag   (est_mag),
        .i_est   (est),
        .o_valid (msk_v),
        .o_item  (msk_item),
        .o_mask  (msk)
    );

    // Scaling product on magnitudes, rounded half up.
    assign abs_re = msk_item.re[15] ? 16'(-msk_item.re) : 16'(msk_item.re);
    assign abs_im = msk_item.im[15] ? 16'(-msk_item.im) : 16'(msk_item.im);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_v <= 1'b0;
        end else if (en) begin
            r_p_v <= msk_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_item <= msk_item;
            r_p_mask <= msk;
            r_p_re   <= (34'(abs_re) * 34'(msk)) + 34'(ONE_Q15);
            r_p_im   <= (34'(abs_im) * 34'(msk)) + 34'(ONE_Q15);
        end
    end

    // Output register restores the sign.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= r_p_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_re   <= r_p_item.re[15] ? 16'(-r_p_re[31:16]) : r_p_re[31:16];
            r_out_im   <= r_p_item.im[15] ? 16'(-r_p_im[31:16]) : r_p_im[31:16];
            r_out_bin  <= r_p_item.idx;
            r_out_mask <= r_p_mask;
        end
    end

    assign o_m_axis_tvalid = r_out_v;
    assign o_m_axis_tdata  = {6'b0, r_out_mask, r_out_bin, r_out_im, r_out_re};

    // The mask never exceeds unity.
    `ASSERT_IMPLIES(a_mask_le_unity, r_out_v, r_out_mask <= UNITY_Q16)
    // A zero mask silences both parts.
    `ASSERT_IMPLIES(a_zero_mask_mutes, r_out_v && (r_out_mask == 17'd0),
        (r_out_re == 16'd0) && (r_out_im == 16'd0))
    // A waiting result stops intake.
    `ASSERT_IMPLIES(a_stall_blocks_input, r_out_v && !i_m_axis_tready, !o_s_axis_tready)

endmodule

// ===== hw/rtl/srs_mag.sv =====
// Bin magnitude pipeline: squares, sum, then one square-root digit per stage.
// Depends on srs_pkg.
module srs_mag import srs_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic         i_valid,
    input  t_item        i_item,
    output logic         o_valid,
    output t_item        o_item,
    output logic [15:0]  o_mag
);

    localparam int Steps = 16;

    logic               r_sq_v;
    t_item              r_sq_item;
    logic signed [31:0] r_sq_re;
    logic signed [31:0] r_sq_im;

    logic        r_v    [0:Steps];
    t_item       r_item [0:Steps];
    logic [31:0] r_x    [0:Steps];
    logic [16:0] r_rem  [0:Steps];
    logic [15:0] r_res  [0:Steps];

    // Squares of both parts.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v <= 1'b0;
        end else if (i_en) begin
            r_sq_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq_item <= i_item;
            r_sq_re   <= i_item.re * i_item.re;
            r_sq_im   <= i_item.im * i_item.im;
        end
    end

    // Sum of squares starts the root.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= r_sq_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item[0] <= r_sq_item;
            r_x[0]    <= 32'(r_sq_re) + 32'(r_sq_im);
            r_rem[0]  <= '0;
            r_res[0]  <= '0;
        end
    end

    // One result bit per stage, two radicand bits consumed each time.
    for (genvar k = 0; k < Steps; k++) begin : g_step
        logic [18:0] rem2;
        logic [18:0] trial;
        logic        take;

        assign rem2  = {r_rem[k], r_x[k][31:30]};
        assign trial = {1'b0, r_res[k], 2'b01};
        assign take  = (rem2 >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_item[k+1] <= r_item[k];
                r_x[k+1]    <= {r_x[k][29:0], 2'b00};
                r_rem[k+1]  <= take ? 17'(rem2 - trial) : 17'(rem2);
                r_res[k+1]  <= {r_res[k][14:0], take};
            end
        end
    end

    assign o_valid = r_v[Steps];
    assign o_item  = r_item[Steps];
    assign o_mag   = r_res[Steps];

endmodule

// ===== hw/rtl/srs_est.sv =====
// Per-bin reverb estimate: memory read, smoothing update with forwarding, write back.
// Depends on srs_pkg.
module srs_est import srs_pkg::*; #(
    parameter int FFT_SIZE = FFT_SIZE_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic [14:0]  i_decay,
    input  logic         i_valid,
    input  t_item        i_item,
    input  logic [15:0]  i_mag,
    output logic         o_valid,
    output t_item        o_item,
    output logic [15:0]  o_mag,
    output logic [16:0]  o_est
);

    localparam int NumBins = FFT_SIZE / 2 + 1;
    localparam int AddrW   = $clog2(NumBins);

    logic [16:0] mem [NumBins];

    logic        r_b_v;
    t_item       r_b_item;
    logic [15:0] r_b_mag;
    logic [31:0] r_b_term;
    logic [16:0] r_b_rd;

    logic        r_c_v;
    t_item       r_c_item;
    logic [15:0] r_c_mag;
    logic [16:0] r_c_est;

    logic [16:0] old_est;
    logic [33:0] acc;
    logic [16:0] new_est;
    logic        fwd;

    // Stage B: read the stored estimate and form the new-magnitude term.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else if (i_en) begin
            r_b_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_item <= i_item;
            r_b_mag  <= i_mag;
            r_b_term <= (32'(ONE_Q15 - 16'(i_decay)) * 32'(i_mag)) + 32'(HALF_Q15);
            r_b_rd   <= mem[AddrW'(i_item.idx)];
        end
    end

    // The item just ahead wrote at the same edge as this read, so take its value.
    assign fwd     = r_c_v && r_c_item.inrng && (r_c_item.idx == r_b_item.idx);
    assign old_est = fwd ? r_c_est : r_b_rd;
    assign acc     = (34'(i_decay) * 34'(old_est)) + 34'(r_b_term);
    assign new_est = r_b_item.first ? 17'(r_b_mag) : acc[31:15];

    // Write back when the item leaves stage B.
    always_ff @(posedge i_clk) begin
        if (i_en && r_b_v && r_b_item.inrng) begin
            mem[AddrW'(r_b_item.idx)] <= new_est;
        end
    end

    // Stage C: registered estimate.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_v <= 1'b0;
        end else if (i_en) begin
            r_c_v <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_item <= r_b_item;
            r_c_mag  <= r_b_mag;
            r_c_est  <= new_est;
        end
    end

    assign o_valid = r_c_v;
    assign o_item  = r_c_item;
    assign o_mag   = r_c_mag;
    assign o_est   = r_c_est;

endmodule

// ===== hw/rtl/srs_mask.sv =====
// Mask pipeline: product of strength and estimate, saturation check, then
// one quotient bit per stage of a restoring division by the magnitude.
// Depends on srs_pkg.
module srs_mask import srs_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_en,
    input  logic [16:0]  i_supp,
    input  logic         i_valid,
    input  t_item        i_item,
    input  logic [15:0]  i_mag,
    input  logic [16:0]  i_est,
    output logic         o_valid,
    output t_item        o_item,
    output logic [16:0]  o_mask
);

    localparam int Steps = 16;

    logic        r_n_v;
    t_item       r_n_item;
    logic [15:0] r_n_mag;
    logic [33:0] r_n_num;

    logic        r_v    [0:Steps];
    t_item       r_item [0:Steps];
    logic [15:0] r_mag  [0:Steps];
    logic [15:0] r_low  [0:Steps];
    logic [15:0] r_rem  [0:Steps];
    logic [15:0] r_q    [0:Steps];
    logic        r_sat  [0:Steps];

    logic        r_m_v;
    t_item       r_m_item;
    logic [16:0] r_m_mask;

    // Numerator of the ratio.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_v <= 1'b0;
        end else if (i_en) begin
            r_n_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n_item <= i_item;
            r_n_mag  <= i_mag;
            r_n_num  <= 34'(i_supp) * 34'(i_est);
        end
    end

    // A ratio of one or more gives a zero mask; a zero magnitude lands here too.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= r_n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_item[0] <= r_n_item;
            r_mag[0]  <= r_n_mag;
            r_low[0]  <= r_n_num[15:0];
            r_rem[0]  <= r_n_num[31:16];
            r_q[0]    <= '0;
            r_sat[0]  <= (r_n_num[33:16] >= 18'(r_n_mag));
        end
    end

    // Restoring division, most significant quotient bit first.
    for (genvar k = 0; k < Steps; k++) begin : g_div
        logic [16:0] rem2;
        logic        take;

        assign rem2 = {r_rem[k], r_low[k][15]};
        assign take = (rem2 >= 17'(r_mag[k]));

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k+1] <= 1'b0;
            end else if (i_en) begin
                r_v[k+1] <= r_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_item[k+1] <= r_item[k];
                r_mag[k+1]  <= r_mag[k];
                r_low[k+1]  <= {r_low[k][14:0], 1'b0};
                r_rem[k+1]  <= take ? 16'(rem2 - 17'(r_mag[k])) : 16'(rem2);
                r_q[k+1]    <= {r_q[k][14:0], take};
                r_sat[k+1]  <= r_sat[k];
            end
        end
    end

    // Final mask; bins beyond the table pass at unity.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_v <= 1'b0;
        end else if (i_en) begin
            r_m_v <= r_v[Steps];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m_item <= r_item[Steps];
            if (!r_item[Steps].inrng) begin
                r_m_mask <= UNITY_Q16;
            end else if (r_sat[Steps]) begin
                r_m_mask <= '0;
            end else begin
                r_m_mask <= UNITY_Q16 - 17'(r_q[Steps]);
            end
        end
    end

    assign o_valid = r_m_v;
    assign o_item  = r_m_item;
    assign o_mask  = r_m_mask;

endmodule

// ===== verif/testbench.sv =====
// Self-checking bench for the spectral reverb suppressor core.
// It predicts each scaled bin and mask from the bin stream and the registers.
// Depends on srs_pkg and spectral_reverb_suppressor_core.
`timescale 1ns / 100ps

module testbench;
    import srs_pkg::*;

    localparam int NUM_BINS = FFT_SIZE_DEF / 2 + 1;
    localparam int PIPE_CYCLES = 60;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic [8:0]         idx;
        logic               first;
    } t_bin;

    typedef struct packed {
        logic [15:0] re;
        logic [15:0] im;
        logic [8:0]  idx;
        logic [16:0] mask;
    } t_scaled;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = CFG_DECAY;
    logic [16:0] i_cfg_wdata = '0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [47:0] i_s_axis_tdata = '0;
    logic [0:0]  i_s_axis_tuser = '0;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [63:0] o_m_axis_tdata;

    spectral_reverb_suppressor_core dut (.*);

    always #1 i_clk = ~i_clk;

    // Predictor state.
    logic [14:0] decay_q15 = DECAY_RST;
    logic [16:0] supp_q16 = SUPP_RST;
    logic [16:0] estimate [NUM_BINS];
    bit          bin_primed [NUM_BINS];

    t_bin    pending_bins[$];
    t_scaled expected_bins[$];
    int      n_mismatch = 0;
    int      idle_cycles = 0;
    bit      stim_done = 1'b0;
    bit      hold_sender = 1'b0;

    function automatic logic [15:0] scale_part(logic signed [15:0] v, logic [16:0] m);
        logic [16:0] mag;
        logic [47:0] p;
        mag = v[15] ? 17'(-$signed({v[15], v})) : 17'(v);
        p = ({31'd0, mag} * {31'd0, m} + 48'd32768) >> 16;
        return v[15] ? 16'(-p) : p[15:0];
    endfunction

    function automatic logic [15:0] int_sqrt(logic [31:0] x);
        logic [31:0] root;
        logic [31:0] bitv;
        root = 0;
        bitv = 32'h4000_0000;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= root + bitv) begin
                x -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root[15:0];
    endfunction

    // Update the bin's estimate and work out the scaled bin.
    function automatic t_scaled predict_bin(t_bin b);
        t_scaled r;
        logic [31:0] sq;
        logic [15:0] mag;
        logic [16:0] est;
        logic [63:0] acc;
        logic [63:0] ratio;
        logic [16:0] m;
        r.idx = b.idx;
        if (b.idx >= NUM_BINS) begin
            r.re = b.re;
            r.im = b.im;
            r.mask = UNITY_Q16;
            return r;
        end
        sq = 32'($signed(b.re) * $signed(b.re)) + 32'($signed(b.im) * $signed(b.im));
        mag = int_sqrt(sq);
        if (b.first) begin
            est = {1'b0, mag};
        end else begin
            acc = 64'(decay_q15) * 64'(estimate[b.idx])
                + 64'(32768 - int'(decay_q15)) * 64'(mag) + 64'd16384;
            est = acc[31:15];
        end
        estimate[b.idx] = est;
        if (mag == 0) begin
            m = '0;
        end else begin
            ratio = (64'(supp_q16) * 64'(est)) / 64'(mag);
            m = (ratio >= 64'd65536) ? 17'd0 : 17'(64'd65536 - ratio);
        end
        r.re = scale_part(b.re, m);
        r.im = scale_part(b.im, m);
        r.mask = m;
        return r;
    endfunction

    function automatic logic signed [15:0] rand_part();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'($urandom_range(0, 40)) - 16'sd20;
            3: return 16'($urandom_range(0, 600)) - 16'sd300;
            default: return 16'($urandom);
        endcase
    endfunction

    // Queue an item; non-first bins only go to bins already primed.
    task automatic push_bin(logic signed [15:0] re, logic signed [15:0] im,
                            logic [8:0] idx, logic first);
        t_bin b;
        b.re = re;
        b.im = im;
        b.idx = idx;
        b.first = first;
        if (idx < NUM_BINS && !first && !bin_primed[idx]) b.first = 1'b1;
        if (idx < NUM_BINS && b.first) bin_primed[idx] = 1'b1;
        pending_bins.push_back(b);
    endtask

    // Wait until every queued item has been sent and every result has come.
    task automatic drain();
        while (pending_bins.size() != 0 || i_s_axis_tvalid || expected_bins.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_CYCLES) @(posedge i_clk);
        while (expected_bins.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_reg r, logic [16:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= r;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (r == CFG_DECAY) decay_q15 = v[14:0];
        else supp_q16 = v;
    endtask

    // Sender: bursts of random length with random gaps.
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                expected_bins.push_back(predict_bin(t_bin'({i_s_axis_tdata[15:0],
                                                            i_s_axis_tdata[31:16],
                                                            i_s_axis_tdata[40:32],
                                                            i_s_axis_tuser[0]})));
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    i_s_axis_tvalid <= 1'b0;
                end else if (pending_bins.size() != 0 && !hold_sender) begin
                    t_bin b;
                    b = pending_bins.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata <= {7'd0, b.idx, b.im, b.re};
                    i_s_axis_tuser <= b.first;
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 40);
                        if ($urandom_range(0, 2) == 0) gap_left <= $urandom_range(1, 12);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern that changes mode from time to time.
    int stall_mode = 0;
    always @(posedge i_clk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: i_m_axis_tready <= 1'b1;
            1: i_m_axis_tready <= ($urandom_range(0, 3) != 0);
            2: i_m_axis_tready <= ($urandom_range(0, 3) == 0);
            default: i_m_axis_tready <= ~i_m_axis_tready;
        endcase
    end

    // Monitor: compare each result item with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            t_scaled got;
            t_scaled want;
            got.re = o_m_axis_tdata[15:0];
            got.im = o_m_axis_tdata[31:16];
            got.idx = o_m_axis_tdata[40:32];
            got.mask = o_m_axis_tdata[57:41];
            if (expected_bins.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result item %h", o_m_axis_tdata);
            end else begin
                want = expected_bins.pop_front();
                if (got != want) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display("mismatch: expected re %h im %h bin %0d mask %0d, got re %h im %h bin %0d mask %0d",
                                 want.re, want.im, want.idx, want.mask,
                                 got.re, got.im, got.idx, got.mask);
                end
            end
        end
    end

    // Watchdog on cycles where nothing moves.
    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                || stim_done || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // A frame of well-formed bins with random content.
    task automatic random_frame(int nbins, bit first);
        int base;
        base = $urandom_range(0, NUM_BINS - nbins);
        for (int k = 0; k < nbins; k++)
            push_bin(rand_part(), rand_part(), 9'(base + k), first);
    endtask

    initial begin
        int total;
        logic [14:0] decays [4];
        logic [16:0] supps [4];
        decays = '{15'd0, 15'd32767, 15'd31457, 15'd16384};
        supps = '{17'd0, 17'd65536, 17'd131071, 17'd58982};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: extremes, zero magnitude, out-of-range bins, repeats on one bin.
        push_bin(16'sh7fff, 16'sh7fff, 9'd0, 1'b1);
        push_bin(16'sh8000, 16'sh8000, 9'd256, 1'b1);
        push_bin(16'sh8000, 16'sh7fff, 9'd1, 1'b1);
        push_bin(16'sd0, 16'sd0, 9'd2, 1'b1);
        push_bin(16'sd0, 16'sd0, 9'd0, 1'b0);
        push_bin(16'sd1, -16'sd1, 9'd0, 1'b0);
        push_bin(16'sh7fff, 16'sh8000, 9'd257, 1'b0);
        push_bin(-16'sd5, 16'sd3, 9'd511, 1'b1);
        push_bin(16'sd100, 16'sd0, 9'd256, 1'b0);
        push_bin(16'sd100, 16'sd0, 9'd256, 1'b0);
        push_bin(16'sh5555, 16'shaaaa, 9'd170, 1'b1);
        push_bin(16'shaaaa, 16'sh5555, 9'd341, 1'b0);
        push_bin(16'sd1, 16'sd0, 9'd1, 1'b0);
        drain();

        total = 0;
        for (int phase = 0; phase < 6; phase++) begin
            write_reg(CFG_DECAY, 17'(decays[phase % 4]));
            write_reg(CFG_SUPP, supps[(phase + 1) % 4]);
            while (total < (phase + 1) * 215) begin
                int n;
                n = $urandom_range(4, 40);
                case ($urandom_range(0, 9))
                    0: begin
                        for (int k = 0; k < n; k++)
                            push_bin(rand_part(), rand_part(), 9'($urandom), 1'($urandom));
                    end
                    1: random_frame(n, 1'b1);
                    default: random_frame(n, 1'b0);
                endcase
                total += n;
            end
            // Pause the sender mid-stream until every result has come back.
            if (phase == 2) begin
                repeat (100) @(posedge i_clk);
                hold_sender = 1'b1;
                @(posedge i_clk);
                while (i_s_axis_tvalid || expected_bins.size() != 0) @(posedge i_clk);
                hold_sender = 1'b0;
            end
            drain();
        end
        stim_done = 1'b1;
        if (n_mismatch == 0 && expected_bins.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/srs_pkg.sv
hw/rtl/srs_mag.sv
hw/rtl/srs_est.sv
hw/rtl/srs_mask.sv
hw/rtl/spectral_reverb_suppressor_core.sv
verif/testbench.sv
